>>> hdl/p64to16_pkg.sv
// ----------------------------------------------------------------------------
// p64to16_pkg
// Shared types and constants for the posit64 (es=2) to posit16 (es=1) converter.
// ----------------------------------------------------------------------------
package p64to16_pkg;

   localparam logic [63:0] NAR64     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] HI_LIM64  = 64'h7FC0_0000_0000_0000;
   localparam logic [63:0] LO_LIM64  = 64'h0040_0000_0000_0000;
   localparam logic [14:0] MAXPOS16  = 15'h7FFF;
   localparam logic [14:0] MINPOS16  = 15'h0001;

   // scale limits of the 16-bit format (es=1, 16 bits)
   localparam logic signed [6:0] SCALE_MAX = 7'sd28;
   localparam logic signed [6:0] SCALE_MIN = -7'sd28;

   // longest regime run searched on the 64-bit side
   localparam int RUN_SEARCH = 10;

   // decoded magnitude handed from the unpack stages to the round stage
   typedef struct packed {
      logic               valid;
      logic               special;      // zero or NaR, pass pattern through
      logic [15:0]        special_pat;
      logic               neg;
      logic               over;         // magnitude above the upper limit
      logic               under;        // magnitude below the lower limit
      logic signed [6:0]  scale;
      logic [14:0]        frac;         // top fraction bits, left-aligned
      logic               sticky;       // OR of all lower fraction bits
   } dec_type;

endpackage

>>> hdl/p64to16_unpack.sv
// ----------------------------------------------------------------------------
// p64to16_unpack
// Two register stages: sign removal and special detection, then regime run
// count, scale and fraction extraction.
// ----------------------------------------------------------------------------
module p64to16_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [63:0]          in_posit,
   output p64to16_pkg::dec_type dec
);
   import p64to16_pkg::*;

   // stage 1 registers
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_special_ff, s1_special_in;
   logic [15:0] s1_pat_ff, s1_pat_in;
   logic        s1_neg_ff, s1_neg_in;
   logic [63:0] s1_mag_ff, s1_mag_in;

   // stage 2 register
   dec_type     s2_ff, s2_in;

   // stage 2 logic
   logic        top;
   logic        found;
   logic [3:0]  run;
   logic [5:0]  e_idx;
   logic [5:0]  f_idx;
   logic [5:0]  st_sh;
   logic [1:0]  exp2;
   logic [63:0] lo_mask;
   logic signed [6:0] k;

   always_comb begin
      s1_valid_in   = in_valid;
      s1_neg_in     = in_posit[63];
      s1_special_in = (in_posit == 64'd0) || (in_posit == NAR64);
      s1_pat_in     = in_posit[63:48];
      s1_mag_in     = in_posit[63] ? (~in_posit + 64'd1) : in_posit;
   end

   always_comb begin
      top   = s1_mag_ff[62];
      found = 1'b0;
      run   = 4'(RUN_SEARCH);
      for (int i = 0; i < RUN_SEARCH; i++) begin
         if (!found && (s1_mag_ff[62-i] != top)) begin
            run   = 4'(i);
            found = 1'b1;
         end
      end
      k       = top ? ($signed({3'b000, run}) - 7'sd1) : -$signed({3'b000, run});
      e_idx   = 6'd61 - {2'b00, run};
      f_idx   = 6'd59 - {2'b00, run};
      st_sh   = 6'd45 - {2'b00, run};
      exp2    = s1_mag_ff[e_idx -: 2];
      lo_mask = ~({64{1'b1}} << st_sh);

      s2_in.valid          = s1_valid_ff;
      s2_in.special        = s1_special_ff;
      s2_in.special_pat    = s1_pat_ff;
      s2_in.neg            = s1_neg_ff;
      s2_in.over           = s1_mag_ff > HI_LIM64;
      s2_in.under          = s1_mag_ff < LO_LIM64;
      s2_in.scale          = (k <<< 2) + $signed({5'b00000, exp2});
      s2_in.frac           = s1_mag_ff[f_idx -: 15];
      s2_in.sticky         = |(s1_mag_ff & lo_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_ff.valid <= s2_in.valid;
      end
      if (advance) begin
         s1_special_ff        <= s1_special_in;
         s1_pat_ff            <= s1_pat_in;
         s1_neg_ff            <= s1_neg_in;
         s1_mag_ff            <= s1_mag_in;
         s2_ff.special        <= s2_in.special;
         s2_ff.special_pat    <= s2_in.special_pat;
         s2_ff.neg            <= s2_in.neg;
         s2_ff.over           <= s2_in.over;
         s2_ff.under          <= s2_in.under;
         s2_ff.scale          <= s2_in.scale;
         s2_ff.frac           <= s2_in.frac;
         s2_ff.sticky         <= s2_in.sticky;
      end
   end

   assign dec = s2_ff;

endmodule

>>> hdl/p64to16_round.sv
// ----------------------------------------------------------------------------
// p64to16_round
// Output stage: regime re-encode, round to nearest even, clamp and re-sign.
// ----------------------------------------------------------------------------
module p64to16_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  p64to16_pkg::dec_type dec,
   output logic                 out_valid,
   output logic [15:0]          out_posit
);
   import p64to16_pkg::*;

   logic              out_valid_ff;
   logic [15:0]       out_posit_ff, out_posit_in;

   logic signed [6:0] kp;
   logic              kp_neg;
   logic [3:0]        rlen;
   logic [3:0]        reg_sh;
   logic [15:0]       reg16;
   logic [15:0]       w16;
   logic [15:0]       v;
   logic              rbit;
   logic              sticky;
   logic [15:0]       sum;
   logic [14:0]       mag;
   logic [15:0]       mag16;

   always_comb begin
      kp     = dec.scale >>> 1;
      kp_neg = kp[6];
      rlen   = kp_neg ? 4'(7'sd1 - kp) : 4'(kp + 7'sd2);
      reg_sh = kp_neg ? 4'(7'sd15 + kp) : 4'(7'sd15 - kp);
      reg16  = kp_neg ? (16'h0001 << reg_sh) : (16'hFFFF << reg_sh);
      w16    = {dec.scale[0], dec.frac};
      v      = reg16 | (w16 >> rlen);
      rbit   = v[0];
      sticky = dec.sticky | (|(w16 & ~(16'hFFFF << rlen)));
      sum    = {1'b0, v[15:1]} + {15'd0, rbit & (sticky | v[1])};

      if (dec.over || (dec.scale >= SCALE_MAX)) begin
         mag = MAXPOS16;
      end else if (dec.under || (dec.scale < SCALE_MIN)) begin
         mag = MINPOS16;
      end else if (sum[15]) begin
         mag = MAXPOS16;
      end else if (sum[14:0] == 15'd0) begin
         mag = MINPOS16;
      end else begin
         mag = sum[14:0];
      end

      mag16 = {1'b0, mag};
      if (dec.special) begin
         out_posit_in = dec.special_pat;
      end else if (dec.neg) begin
         out_posit_in = ~mag16 + 16'd1;
      end else begin
         out_posit_in = mag16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dec.valid;
      end
      if (advance) begin
         out_posit_ff <= out_posit_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_posit = out_posit_ff;

endmodule

>>> hdl/posit64_to_posit16_convert_top.sv
// ----------------------------------------------------------------------------
// posit64_to_posit16_convert_top
// Converts a 64-bit posit (es=2) to the nearest 16-bit posit (es=1).
// ----------------------------------------------------------------------------
// Three-stage pipeline: one beat is taken every clock unless the pipe is
// stalled, and its result appears on the rsp side once it has passed the
// three register stages (negate/special detect, regime decode, round/pack).
// A stall on rsp (while rsp_valid is high) holds every stage in place and
// raises req_stall in the same cycle. Zero and NaR pass straight through;
// out-of-range magnitudes clamp to maxpos or minpos with the input's sign.
module posit64_to_posit16_convert_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_posit_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_posit_out
);
   import p64to16_pkg::*;

   logic    advance;
   dec_type dec;

   // advance the whole pipe unless the output beat is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   p64to16_unpack u_unpack (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_posit (req_posit_in),
      .dec      (dec)
   );

   p64to16_round u_round (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .dec       (dec),
      .out_valid (rsp_valid),
      .out_posit (rsp_posit_out)
   );

   a_over_under_exclusive : assert property (@(posedge clock) disable iff (reset)
      dec.valid |-> !(dec.over && dec.under))
      else $error("decoded magnitude flagged both over and under");

   a_special_passthrough : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && ((req_posit_in == 64'd0) || (req_posit_in == NAR64)))
      ##1 advance ##1 advance
      |=> rsp_valid && (rsp_posit_out == $past(req_posit_in[63:48], 3)))
      else $error("zero or NaR not passed through");

   a_sign_kept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_posit_in != 64'd0) && (req_posit_in != NAR64))
      ##1 advance ##1 advance
      |=> rsp_valid && (rsp_posit_out != 16'h0000) && (rsp_posit_out != 16'h8000)
          && (rsp_posit_out[15] == $past(req_posit_in[63], 3)))
      else $error("real input gave zero, NaR or wrong sign");

endmodule
